/* hdl/ptx4_pkg.sv */
// ---------------------------------------------------------------------------
// ptx4_pkg
// shared widths and constants of the 4x4 point transform pipeline
// ---------------------------------------------------------------------------
package ptx4_pkg;

  localparam int FRAC_BITS = 16;                  // fraction bits of the fixed point format
  localparam int DW        = 32;                  // coordinate and matrix entry width
  localparam int PW        = 2 * DW;              // exact product width
  localparam int SW        = PW + 2;              // exact sum of three products
  localparam int NW        = SW - FRAC_BITS + 1;  // floored numerator plus row 3 term
  localparam int CW        = NW + FRAC_BITS + DW + 1;  // divider remainder width
  localparam int DS        = DW;                  // one quotient bit per divider stage
  localparam int MN        = 16;                  // matrix entries
  localparam int MIW       = 4;                   // matrix index width

  localparam logic CMD_LOAD      = 1'b0;
  localparam logic CMD_TRANSFORM = 1'b1;

  localparam logic [DW-1:0] FIX_ONE  = DW'(1) << FRAC_BITS;
  localparam logic [DW-1:0] FIX_ZERO = '0;
  localparam logic [DW-1:0] SAT_MAX  = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SAT_MIN  = {1'b1, {(DW-1){1'b0}}};

endpackage

/* hdl/point_transform_4x4.sv */
// ---------------------------------------------------------------------------
// point_transform_4x4
// homogeneous vertex transform with perspective divide, fixed point
// ---------------------------------------------------------------------------
//
//   channel | ports                                          | direction
//   --------+------------------------------------------------+----------
//   input   | in_valid in_stall in_cmd in_elem_* in_x/y/z    | in
//   result  | out_valid out_stall out_x/y/z out_w_zero       | out
//
// one beat enters per cycle unless the pipeline is held; a transform beat
// runs through stages 1 to 3, divider setup and 32 restoring divider stages
// (one quotient bit per stage, three dividers side by side for x, y, z)
// a load beat writes its matrix entry at acceptance and yields no result
// the whole pipeline moves on a single enable; it holds only while a result
// sits in the output register and out_stall is high
// reset (synchronous, rst_n low) clears all valid bits and loads identity
//
module point_transform_4x4 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [3:0]  in_elem_index,
  input  logic [31:0] in_elem_value,
  input  logic [31:0] in_x,
  input  logic [31:0] in_y,
  input  logic [31:0] in_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [31:0] out_z,
  output logic        out_w_zero
);

  localparam int F  = ptx4_pkg::FRAC_BITS;
  localparam int DW = ptx4_pkg::DW;
  localparam int PW = ptx4_pkg::PW;
  localparam int SW = ptx4_pkg::SW;
  localparam int NW = ptx4_pkg::NW;
  localparam int CW = ptx4_pkg::CW;
  localparam int DS = ptx4_pkg::DS;
  localparam int MN = ptx4_pkg::MN;

  // global pipeline enable
  logic pipe_en;
  logic in_accept;
  assign pipe_en   = ~out_valid | ~out_stall;
  assign in_stall  = ~pipe_en;
  assign in_accept = in_valid & pipe_en;

  // matrix store, row-vector layout row*4+col
  logic [DW-1:0] mat_r [MN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MN; i++) begin
        mat_r[i] <= (i % 5 == 0) ? ptx4_pkg::FIX_ONE : ptx4_pkg::FIX_ZERO;
      end
    end else if (in_accept && in_cmd == ptx4_pkg::CMD_LOAD) begin
      mat_r[in_elem_index] <= in_elem_value;
    end
  end

  // stage 1: twelve exact products and the row 3 terms
  logic        v1_r;
  logic signed [PW-1:0] prod_r [4][3];
  logic [DW-1:0]        m3_r   [4];
  logic signed [DW-1:0] pt [3];

  assign pt[0] = $signed(in_x);
  assign pt[1] = $signed(in_y);
  assign pt[2] = $signed(in_z);

  // stage 2: floored column sums plus row 3
  logic        v2_r;
  logic signed [NW-1:0] num_r [4];
  logic signed [SW-1:0] sum_w [4];
  logic signed [SW-1:0] fl_w  [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum_w[c] = SW'(prod_r[c][0]) + SW'(prod_r[c][1]) + SW'(prod_r[c][2]);
      fl_w[c]  = sum_w[c] >>> F;
    end
  end

  // stage 3: magnitudes, signs, zero test on w
  logic          v3_r;
  logic [NW-1:0] mag_r [3];
  logic [NW-1:0] den_r;
  logic          neg_r [3];
  logic          wz_r;

  // divider stages, index 0 is the setup stage with the overflow test
  logic          dv_r   [DS+1];
  logic [CW-1:0] rem_r  [DS+1][3];
  logic [DW-1:0] q_r    [DS+1][3];
  logic          ovf_r  [DS+1][3];
  logic          dneg_r [DS+1][3];
  logic [NW-1:0] dden_r [DS+1];
  logic          dwz_r  [DS+1];

  logic [CW-1:0] shd_w  [DS];
  logic [CW:0]   diff_w [DS][3];

  always_comb begin
    for (int j = 0; j < DS; j++) begin
      shd_w[j] = CW'(dden_r[j]) << (DS - 1 - j);
      for (int c = 0; c < 3; c++) begin
        diff_w[j][c] = {1'b0, rem_r[j][c]} - {1'b0, shd_w[j]};
      end
    end
  end

  // output register
  logic          out_valid_r;
  logic [DW-1:0] out_c_r [3];
  logic          out_wz_r;
  logic [DW-1:0] res_w   [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (dwz_r[DS]) begin
        res_w[c] = ptx4_pkg::FIX_ZERO;
      end else if (dneg_r[DS][c]) begin
        res_w[c] = (ovf_r[DS][c] | q_r[DS][c][DW-1]) ? ptx4_pkg::SAT_MIN : -q_r[DS][c];
      end else begin
        res_w[c] = (ovf_r[DS][c] | q_r[DS][c][DW-1]) ? ptx4_pkg::SAT_MAX : q_r[DS][c];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int j = 0; j <= DS; j++) begin
        dv_r[j] <= 1'b0;
      end
    end else if (pipe_en) begin
      v1_r    <= in_accept & (in_cmd == ptx4_pkg::CMD_TRANSFORM);
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      dv_r[0] <= v3_r;
      for (int j = 0; j < DS; j++) begin
        dv_r[j+1] <= dv_r[j];
      end
      out_valid_r <= dv_r[DS];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 3; r++) begin
          prod_r[c][r] <= pt[r] * $signed(mat_r[r*4+c]);
        end
        m3_r[c]  <= mat_r[12+c];
        num_r[c] <= fl_w[c][NW-1:0] + {{(NW-DW){m3_r[c][DW-1]}}, m3_r[c]};
      end

      for (int c = 0; c < 3; c++) begin
        mag_r[c] <= num_r[c][NW-1] ? NW'(-num_r[c]) : NW'(num_r[c]);
        neg_r[c] <= num_r[c][NW-1] ^ num_r[3][NW-1];
      end
      den_r <= num_r[3][NW-1] ? NW'(-num_r[3]) : NW'(num_r[3]);
      wz_r  <= (num_r[3] == '0);

      for (int c = 0; c < 3; c++) begin
        rem_r[0][c]  <= CW'(mag_r[c]) << F;
        ovf_r[0][c]  <= (CW'(mag_r[c]) << F) >= (CW'(den_r) << DW);
        q_r[0][c]    <= '0;
        dneg_r[0][c] <= neg_r[c];
      end
      dden_r[0] <= den_r;
      dwz_r[0]  <= wz_r;

      // one restoring step per stage, quotient msb first
      for (int j = 0; j < DS; j++) begin
        for (int c = 0; c < 3; c++) begin
          if (diff_w[j][c][CW]) begin
            rem_r[j+1][c] <= rem_r[j][c];
            q_r[j+1][c]   <= q_r[j][c];
          end else begin
            rem_r[j+1][c] <= diff_w[j][c][CW-1:0];
            q_r[j+1][c]   <= q_r[j][c] | (DW'(1) << (DS - 1 - j));
          end
          ovf_r[j+1][c]  <= ovf_r[j][c];
          dneg_r[j+1][c] <= dneg_r[j][c];
        end
        dden_r[j+1] <= dden_r[j];
        dwz_r[j+1]  <= dwz_r[j];
      end

      for (int c = 0; c < 3; c++) begin
        out_c_r[c] <= res_w[c];
      end
      out_wz_r <= dwz_r[DS];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_x      = out_c_r[0];
  assign out_y      = out_c_r[1];
  assign out_z      = out_c_r[2];
  assign out_w_zero = out_wz_r;

`ifndef SYNTH
  // an empty output register never holds back the input
  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall) else $error("input stalled with empty output");

  // a zero w result carries zero coordinates
  a_wz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_w_zero) |-> (out_x == '0 && out_y == '0 && out_z == '0))
    else $error("w_zero result with nonzero coordinates");

  // a load beat never produces a result at the first stage
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_cmd == ptx4_pkg::CMD_LOAD) |=> !v1_r)
    else $error("load beat entered the transform path");
`endif

endmodule

/* bench/point_transform_4x4_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// point_transform_4x4_tb
// checks matrix loads and point transforms against a bit-exact predictor;
// random bursts on the input side, random stalls on the result side
// ---------------------------------------------------------------------------
module point_transform_4x4_tb;

  // one expected transform result
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        w_zero;
  } vertex_t;

  // keeps the shadow matrix and the queue of expected vertices
  class vertex_scoreboard;
    logic [31:0] mat [ptx4_pkg::MN];
    vertex_t     pending [$];
    int          errors;

    function void clear_matrix();
      for (int i = 0; i < ptx4_pkg::MN; i++)
        mat[i] = (i % 5 == 0) ? ptx4_pkg::FIX_ONE : ptx4_pkg::FIX_ZERO;
    endfunction

    // mismatch reporting, one line each
    task report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got);
      $display("mismatch %s: expected %h got %h at %0t", what, exp_v, got, $realtime);
      errors++;
    endtask

    // floored column sum plus row 3 term, exact in a wide signed vector
    function logic signed [127:0] column_sum(logic signed [31:0] px, logic signed [31:0] py,
                                             logic signed [31:0] pz, int col);
      logic signed [127:0] acc;
      acc = 128'(px) * 128'($signed(mat[col])) + 128'(py) * 128'($signed(mat[4 + col]))
          + 128'(pz) * 128'($signed(mat[8 + col]));
      acc = acc >>> ptx4_pkg::FRAC_BITS;
      return acc + 128'($signed(mat[12 + col]));
    endfunction

    // quotient scaled by 2^FRAC_BITS, truncated toward zero, saturated
    function logic [31:0] scaled_div(logic signed [127:0] num, logic signed [127:0] den);
      logic [127:0] a;
      logic [127:0] b;
      logic [127:0] q;
      logic         neg;
      neg = (num < 0) != (den < 0);
      a = (num < 0) ? -num : num;
      b = (den < 0) ? -den : den;
      q = (a << ptx4_pkg::FRAC_BITS) / b;
      if (neg) return (q >= 128'h8000_0000) ? ptx4_pkg::SAT_MIN : 32'(-q);
      return (q > 128'h7fff_ffff) ? ptx4_pkg::SAT_MAX : q[31:0];
    endfunction

    function void note_input(logic cmd, logic [3:0] idx, logic [31:0] val,
                             logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      logic signed [127:0] w;
      vertex_t v;
      if (cmd == ptx4_pkg::CMD_LOAD) begin
        mat[idx] = val;
        return;
      end
      w = column_sum(px, py, pz, 3);
      if (w == 0) begin
        v = '{x: '0, y: '0, z: '0, w_zero: 1'b1};
      end else begin
        v.x = scaled_div(column_sum(px, py, pz, 0), w);
        v.y = scaled_div(column_sum(px, py, pz, 1), w);
        v.z = scaled_div(column_sum(px, py, pz, 2), w);
        v.w_zero = 1'b0;
      end
      pending.push_back(v);
    endfunction

    task check_result(vertex_t got);
      vertex_t exp_v;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing pending", 0, got.x);
        return;
      end
      exp_v = pending.pop_front();
      if (got.x !== exp_v.x) report_mismatch("out_x", exp_v.x, got.x);
      if (got.y !== exp_v.y) report_mismatch("out_y", exp_v.y, got.y);
      if (got.z !== exp_v.z) report_mismatch("out_z", exp_v.z, got.z);
      if (got.w_zero !== exp_v.w_zero) report_mismatch("out_w_zero", exp_v.w_zero, got.w_zero);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_cmd;
  logic [3:0]  in_elem_index;
  logic [31:0] in_elem_value;
  logic [31:0] in_x;
  logic [31:0] in_y;
  logic [31:0] in_z;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic        out_w_zero;

  vertex_scoreboard sb;
  int  idle_cycles;
  int  stall_mode;

  localparam int IDLE_LIMIT = 4000;
  localparam int LATENCY    = 40;

  point_transform_4x4 dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // send one beat, holding it until accepted
  task automatic send_beat(logic cmd, logic [3:0] idx, logic [31:0] val,
                           logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_elem_index <= idx;
    in_elem_value <= val;
    in_x          <= px;
    in_y          <= py;
    in_z          <= pz;
    do @(posedge clk); while (in_stall);
    sb.note_input(cmd, idx, val, px, py, pz);
  endtask

  task automatic pause_beats(int n);
    if (n == 0) return;
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic load_entry(int idx, logic [31:0] val);
    send_beat(ptx4_pkg::CMD_LOAD, 4'(idx), val, $urandom, $urandom, $urandom);
  endtask

  task automatic transform_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    send_beat(ptx4_pkg::CMD_TRANSFORM, 4'($urandom), $urandom, px, py, pz);
  endtask

  // field values weighted toward small and edge cases
  function automatic logic [31:0] pick_fix();
    case ($urandom_range(0, 7))
      0: return ptx4_pkg::SAT_MAX;
      1: return ptx4_pkg::SAT_MIN;
      2: return ptx4_pkg::FIX_ZERO;
      3, 4: return 32'($signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000);
      default: return $urandom;
    endcase
  endfunction

  // result side: accept and check, stall on a shifting pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_result('{x: out_x, y: out_y, z: out_z, w_zero: out_w_zero});
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);

  initial begin
    sb = new();
    sb.clear_matrix();
    idle_cycles = 0;
    stall_mode  = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_cmd <= ptx4_pkg::CMD_LOAD;
    in_elem_index <= '0;
    in_elem_value <= '0;
    in_x <= '0;
    in_y <= '0;
    in_z <= '0;
    out_stall <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: identity matrix, edge coordinates
    transform_point(ptx4_pkg::FIX_ONE, 32'hfffe_0000, 32'h0000_8000);
    transform_point(ptx4_pkg::SAT_MAX, ptx4_pkg::SAT_MIN, ptx4_pkg::FIX_ZERO);
    // zero w: clear the w column's translation term
    load_entry(15, ptx4_pkg::FIX_ZERO);
    transform_point(ptx4_pkg::FIX_ONE, ptx4_pkg::FIX_ONE, ptx4_pkg::FIX_ONE);
    // tiny w drives the quotients into saturation both ways
    load_entry(15, 32'h0000_0001);
    transform_point(ptx4_pkg::SAT_MAX, ptx4_pkg::SAT_MIN, ptx4_pkg::FIX_ONE);
    // negative w and extreme entries
    load_entry(15, ptx4_pkg::SAT_MIN);
    load_entry(0, ptx4_pkg::SAT_MAX);
    load_entry(5, ptx4_pkg::SAT_MIN);
    load_entry(11, 32'hffff_0000);
    transform_point(ptx4_pkg::SAT_MIN, ptx4_pkg::SAT_MAX, ptx4_pkg::SAT_MAX);
    transform_point(32'h0001_8000, 32'hffff_8000, 32'h0002_0000);
    // w column all ones, load then use in back-to-back beats
    for (int i = 3; i < 16; i += 4) load_entry(i, ptx4_pkg::FIX_ONE);
    transform_point(32'hffff_0000, ptx4_pkg::FIX_ZERO, ptx4_pkg::FIX_ZERO);
    transform_point(ptx4_pkg::FIX_ONE, ptx4_pkg::FIX_ONE, ptx4_pkg::FIX_ONE);

    // random: mostly transforms over a matrix that changes now and then
    for (int n = 0; n < 1230; n++) begin
      if (n == 600) begin
        // hold off until the pipeline drains
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 4) == 0)
        load_entry($urandom_range(0, 15), ($urandom_range(0, 3) == 0) ?
                   ptx4_pkg::FIX_ONE : pick_fix());
      else
        transform_point(pick_fix(), pick_fix(), pick_fix());
      if ($urandom_range(0, 11) == 0) pause_beats($urandom_range(1, 30));
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

/* sim.f */
hdl/ptx4_pkg.sv
hdl/point_transform_4x4.sv
bench/point_transform_4x4_tb.sv
